[rtl/wwd_pkg.sv]
`default_nettype none

package wwd_pkg;

	localparam logic       CMD_ADD    = 1'b0;
	localparam logic       CMD_SEARCH = 1'b1;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_FULL   = 2'd1;
	localparam logic [1:0] ERR_LONG   = 2'd2;

	localparam logic [7:0] WILDCARD   = 8'd46;

	// per-character transaction traveling down the cell chain
	typedef struct packed {
		logic       cmd;
		logic [7:0] ch;
		logic       last;
		logic       drop;   // position beyond the maximum length
		logic       ovf;    // word has run past the maximum length
		logic       taken;  // an earlier free cell has claimed this word
		logic       match;  // an earlier cell matched this word
	} tok_t;

endpackage

`default_nettype wire

[rtl/wwd_front.sv]
`default_nettype none

module wwd_front import wwd_pkg::*; #(
	parameter int MAX_LEN = 32,
	localparam int PW = $clog2(MAX_LEN + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          in_valid,
	input  wire logic          command,
	input  wire logic [7:0]    char_code,
	input  wire logic          last_char,
	output logic               tok_vld,
	output tok_t               tok,
	output logic [PW-1:0]      pos
);

	localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN);
	localparam logic [PW-1:0] ONE     = PW'(1);

	logic [PW-1:0] pos_q;
	logic          ovf_q;
	logic          vld_s1;
	tok_t          tok_s1;
	logic [PW-1:0] pos_s1;
	logic          accept;
	logic          drop;

	assign accept = in_valid && adv;
	assign drop   = (pos_q == POS_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ovf_q  <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= in_valid;
			end
			if (accept) begin
				if (last_char) begin
					pos_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					if (!drop) begin
						pos_q <= pos_q + ONE;
					end
					ovf_q <= ovf_q | drop;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s1.cmd   <= command;
			tok_s1.ch    <= char_code;
			tok_s1.last  <= last_char;
			tok_s1.drop  <= drop;
			tok_s1.ovf   <= ovf_q | drop;
			tok_s1.taken <= 1'b0;
			tok_s1.match <= 1'b0;
			pos_s1       <= pos_q;
		end
	end

	assign tok_vld = vld_s1;
	assign tok     = tok_s1;
	assign pos     = pos_s1;

endmodule

`default_nettype wire

[rtl/wwd_cell.sv]
`default_nettype none

module wwd_cell import wwd_pkg::*; #(
	parameter int MAX_LEN = 32,
	localparam int PW = $clog2(MAX_LEN + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          in_vld,
	input  wire tok_t          in_tok,
	input  wire logic [PW-1:0] in_pos,
	output logic               out_vld,
	output tok_t               out_tok,
	output logic [PW-1:0]      out_pos
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [PW-1:0] ONE = PW'(1);

	logic [7:0]    mem_q [MAX_LEN];
	logic [PW-1:0] len_q;
	logic          filled_q;
	logic          cand_q;

	logic          vld_s1;
	tok_t          tok_s1;
	logic [PW-1:0] pos_s1;
	logic [7:0]    rd_s1;
	logic          fwd_s1;
	logic [7:0]    wdat_s1;

	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic [7:0]    stored;
	logic [PW-1:0] len_n;
	logic          live;
	logic          mism;
	logic          cand_n;
	logic          hit;
	logic          fill;
	tok_t          tok_n;

	assign rd_addr = in_pos[AW-1:0];
	assign wr_addr = pos_s1[AW-1:0];
	assign stored  = fwd_s1 ? wdat_s1 : rd_s1;
	assign len_n   = pos_s1 + ONE;
	assign live    = vld_s1 && !tok_s1.drop;
	assign wr_en   = adv && live && !filled_q && !tok_s1.taken;
	assign mism    = filled_q && (tok_s1.ch != WILDCARD) &&
			((pos_s1 >= len_q) || (stored != tok_s1.ch));
	assign cand_n  = cand_q && !(live && mism);
	assign hit     = filled_q && cand_n && (len_q == len_n);
	assign fill    = adv && vld_s1 && tok_s1.last && !tok_s1.ovf &&
			(tok_s1.cmd == CMD_ADD) && !filled_q && !tok_s1.taken;

	always_comb begin
		tok_n       = tok_s1;
		tok_n.taken = tok_s1.taken | !filled_q;
		tok_n.match = tok_s1.match | (tok_s1.last && hit);
	end

	// stage A: word store read, with bypass of the write in the same cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= tok_s1.ch;
		end
		if (adv) begin
			rd_s1   <= mem_q[rd_addr];
			fwd_s1  <= wr_en && (wr_addr == rd_addr);
			wdat_s1 <= tok_s1.ch;
			tok_s1  <= in_tok;
			pos_s1  <= in_pos;
		end
		if (fill) begin
			len_q <= len_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			filled_q <= 1'b0;
			cand_q   <= 1'b1;
		end else begin
			if (adv) begin
				vld_s1 <= in_vld;
				if (vld_s1) begin
					cand_q <= tok_s1.last ? 1'b1 : cand_n;
				end
			end
			if (fill) begin
				filled_q <= 1'b1;
			end
		end
	end

	assign out_vld = vld_s1;
	assign out_tok = tok_n;
	assign out_pos = pos_s1;

endmodule

`default_nettype wire

[rtl/wildcard_word_dictionary_core.sv]
// A last character passes the front, every cell and the result register to out_valid.
// Throughput: one character per cycle; each word entry is a one-stage cell in a chain.
// The whole chain stalls only while a result waits on out_ready.
// Reset: asynchronous, active low; the store starts empty with no clearing pass.
// Stored characters beyond an entry's length stay undefined and are never compared.
`default_nettype none

module wildcard_word_dictionary_core import wwd_pkg::*; #(
	parameter int MAX_WORDS = 256,
	parameter int MAX_LEN   = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       command,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            matched,
	output logic [1:0]      error
);

	localparam int PW = $clog2(MAX_LEN + 1);

	logic          adv;
	logic          chain_vld [MAX_WORDS+1];
	tok_t          chain_tok [MAX_WORDS+1];
	logic [PW-1:0] chain_pos [MAX_WORDS+1];
	logic          out_valid_q;
	logic          matched_q;
	logic [1:0]    error_q;
	tok_t          tail;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	wwd_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.command  (command),
		.char_code(char_code),
		.last_char(last_char),
		.tok_vld  (chain_vld[0]),
		.tok      (chain_tok[0]),
		.pos      (chain_pos[0])
	);

	for (genvar i = 0; i < MAX_WORDS; i++) begin : g_cell
		wwd_cell #(.MAX_LEN(MAX_LEN)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.in_vld (chain_vld[i]),
			.in_tok (chain_tok[i]),
			.in_pos (chain_pos[i]),
			.out_vld(chain_vld[i+1]),
			.out_tok(chain_tok[i+1]),
			.out_pos(chain_pos[i+1])
		);
	end

	assign tail = chain_tok[MAX_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain_vld[MAX_WORDS] && tail.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && chain_vld[MAX_WORDS] && tail.last) begin
			matched_q <= (tail.cmd == CMD_SEARCH) && !tail.ovf && tail.match;
			if (tail.ovf) begin
				error_q <= ERR_LONG;
			end else if ((tail.cmd == CMD_ADD) && !tail.taken) begin
				error_q <= ERR_FULL;
			end else begin
				error_q <= ERR_NONE;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign error     = error_q;

endmodule

`default_nettype wire

[rtl/wwd_checker.sv]
`default_nettype none

module wwd_checker import wwd_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       matched,
	input wire logic [1:0] error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(error))
		else $error("result changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !(in_valid && in_ready))
		else $error("input taken while result stalled");

	a_match_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && (error != ERR_NONE)) && (error != 2'd3))
		else $error("bad result code");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result during reset");

endmodule

bind wildcard_word_dictionary_core wwd_checker u_wwd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.matched  (matched),
	.error    (error)
);

`default_nettype wire
